// ===== design/ncc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types, character codes and helpers for the literal classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned POS_W  = 2;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [POS_W-1:0]  t_pos;

    // character codes
    localparam t_char C_ZERO    = 8'h30;
    localparam t_char C_ONE     = 8'h31;
    localparam t_char C_SEVEN   = 8'h37;
    localparam t_char C_NINE    = 8'h39;
    localparam t_char C_LC_A    = 8'h61;
    localparam t_char C_LC_F    = 8'h66;
    localparam t_char C_UC_A    = 8'h41;
    localparam t_char C_UC_F    = 8'h46;
    localparam t_char C_LC_X    = 8'h78;
    localparam t_char C_UC_X    = 8'h58;
    localparam t_char C_LC_H    = 8'h68;
    localparam t_char C_UC_H    = 8'h48;
    localparam t_char C_LC_D    = 8'h64;
    localparam t_char C_UC_D    = 8'h44;
    localparam t_char C_LC_O    = 8'h6f;
    localparam t_char C_UC_O    = 8'h4f;
    localparam t_char C_LC_B    = 8'h62;
    localparam t_char C_UC_B    = 8'h42;
    localparam logic [3:0] HEX_TEN = 4'ha;

    // positions in the character count
    localparam t_pos POS_FIRST  = 2'd0;
    localparam t_pos POS_SECOND = 2'd1;
    localparam t_pos POS_LATER  = 2'd2;

    // pattern flag bits
    localparam int unsigned FL_HEX_ALL  = 0;
    localparam int unsigned FL_HEX_TAIL = 1;
    localparam int unsigned FL_DEC_ALL  = 2;
    localparam int unsigned FL_OCT_ALL  = 3;
    localparam int unsigned FL_OCT_TAIL = 4;
    localparam int unsigned FL_BIN_ALL  = 5;
    localparam int unsigned FL_W        = 6;

    typedef logic [FL_W-1:0] t_flags;
    localparam t_flags FL_RESET = '1;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex_digit;

    function automatic t_hex_digit hex_digit(input t_char c);
        t_hex_digit d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= C_ZERO && c <= C_NINE) begin
            d.val = 4'(c - C_ZERO);
        end else if (c >= C_LC_A && c <= C_LC_F) begin
            d.val = 4'(c - C_LC_A) + HEX_TEN;
        end else if (c >= C_UC_A && c <= C_UC_F) begin
            d.val = 4'(c - C_UC_A) + HEX_TEN;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== design/ncc_if.sv =====
// ----------------------------------------------------------------------------
// ncc_in_if / ncc_out_if
// Valid/ready channels: character requests in, classification results out.
// ----------------------------------------------------------------------------
interface ncc_in_if
    import ncc_pkg::*;
;
    logic  valid;
    logic  ready;
    t_char char_code;
    logic  is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ncc_out_if
    import ncc_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   hex_ok;
    logic   dec_ok;
    logic   oct_ok;
    logic   bin_ok;
    t_value hex_value;
    t_value dec_value;
    t_value oct_value;
    t_value bin_value;

    modport source (output valid, output hex_ok, output dec_ok, output oct_ok,
                    output bin_ok, output hex_value, output dec_value,
                    output oct_value, output bin_value, input ready);
    modport sink   (input valid, input hex_ok, input dec_ok, input oct_ok,
                    input bin_ok, input hex_value, input dec_value,
                    input oct_value, input bin_value, output ready);
endinterface

// ===== design/number_literal_classify_convert_core.sv =====
// ----------------------------------------------------------------------------
// number_literal_classify_convert_core
// Classifies an integer literal by radix and converts it, one character
// per request.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the input side is not held, with
// is_last marking the end of a literal. On the last character a single
// result appears: four flags saying whether the literal is valid hex (0x/0X
// prefix, else h/H suffix), decimal (optional d/D suffix), octal (leading 0,
// else o/O suffix) and binary (optional b/B suffix), plus the value of the
// digits of each radix, other characters skipped, wrapping at 64 bits.
// Throughput is one character per cycle, set by the shift-add accumulators.
// A last character that is taken waits in the input register, and its
// result is then registered in the result register, which presents it. The
// result register lets further characters be taken while a result waits;
// only a last character that meets a stalled result holds the input side.
// State returns to its reset values after every literal.
// ----------------------------------------------------------------------------
module number_literal_classify_convert_core
    import ncc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ncc_in_if.sink    i_req,
    ncc_out_if.source o_res
);

    // input register
    logic  r_in_valid;
    t_char r_char;
    logic  r_last;

    // literal state
    t_pos   r_pos,        n_pos;
    logic   r_first_zero, n_first_zero;
    logic   r_hex_prefix, n_hex_prefix;
    t_flags r_flags,      n_flags;
    t_value r_hex_acc,    n_hex_acc;
    t_value r_dec_acc,    n_dec_acc;
    t_value r_oct_acc,    n_oct_acc;
    t_value r_bin_acc,    n_bin_acc;

    // result register
    logic   r_out_valid;
    logic   r_hex_ok, r_dec_ok, r_oct_ok, r_bin_ok;
    t_value r_hex_val, r_dec_val, r_oct_val, r_bin_val;

    logic   out_free;
    logic   proc;
    logic   in_take;

    t_hex_digit hd;
    logic   dg, oc, bn, is_x, is_h, is_d, is_o, is_b;
    logic   prefix;
    logic   n_hex_ok, n_dec_ok, n_oct_ok, n_bin_ok;
    t_value dec_step;

    // a non-last character never needs the result register
    assign out_free    = !r_out_valid || o_res.ready;
    assign proc        = r_in_valid && (!r_last || out_free);
    assign i_req.ready = !r_in_valid || proc;
    assign in_take     = i_req.valid && i_req.ready;

    // character decode
    always_comb begin
        hd   = hex_digit(r_char);
        dg   = (r_char >= C_ZERO) && (r_char <= C_NINE);
        oc   = (r_char >= C_ZERO) && (r_char <= C_SEVEN);
        bn   = (r_char == C_ZERO) || (r_char == C_ONE);
        is_x = (r_char == C_LC_X) || (r_char == C_UC_X);
        is_h = (r_char == C_LC_H) || (r_char == C_UC_H);
        is_d = (r_char == C_LC_D) || (r_char == C_UC_D);
        is_o = (r_char == C_LC_O) || (r_char == C_UC_O);
        is_b = (r_char == C_LC_B) || (r_char == C_UC_B);
    end

    // accumulators: x16, x10 as x8 + x2, x8, x2
    always_comb begin
        dec_step  = {r_dec_acc[VAL_W-4:0], 3'b000} + {r_dec_acc[VAL_W-2:0], 1'b0}
                  + VAL_W'(r_char - C_ZERO);
        n_hex_acc = hd.ok ? {r_hex_acc[VAL_W-5:0], hd.val} : r_hex_acc;
        n_dec_acc = dg ? dec_step : r_dec_acc;
        n_oct_acc = oc ? {r_oct_acc[VAL_W-4:0], r_char[2:0]} : r_oct_acc;
        n_bin_acc = bn ? {r_bin_acc[VAL_W-2:0], r_char[0]} : r_bin_acc;
    end

    // validity on the last character
    always_comb begin
        prefix = r_hex_prefix || ((r_pos == POS_SECOND) && r_first_zero && is_x);
        priority if (prefix) begin
            n_hex_ok = (r_pos == POS_SECOND) || (r_flags[FL_HEX_TAIL] && hd.ok);
        end else if (is_h) begin
            n_hex_ok = r_flags[FL_HEX_ALL];
        end else begin
            n_hex_ok = 1'b0;
        end

        n_dec_ok = r_flags[FL_DEC_ALL] && (dg || is_d);

        priority if (r_pos == POS_FIRST) begin
            n_oct_ok = (r_char == C_ZERO) || is_o;
        end else if (r_first_zero) begin
            n_oct_ok = r_flags[FL_OCT_TAIL] && oc;
        end else begin
            n_oct_ok = r_flags[FL_OCT_ALL] && is_o;
        end

        n_bin_ok = r_flags[FL_BIN_ALL] && (bn || is_b);
    end

    // state update for a character that is not the last
    always_comb begin
        n_flags = r_flags;
        if (!hd.ok)                         n_flags[FL_HEX_ALL]  = 1'b0;
        if (r_pos == POS_LATER && !hd.ok)   n_flags[FL_HEX_TAIL] = 1'b0;
        if (!dg)                            n_flags[FL_DEC_ALL]  = 1'b0;
        if (!oc)                            n_flags[FL_OCT_ALL]  = 1'b0;
        if (r_pos != POS_FIRST && !oc)      n_flags[FL_OCT_TAIL] = 1'b0;
        if (!bn)                            n_flags[FL_BIN_ALL]  = 1'b0;

        n_first_zero = r_first_zero;
        n_hex_prefix = r_hex_prefix;
        if (r_pos == POS_FIRST) begin
            n_first_zero = (r_char == C_ZERO);
        end else if (r_pos == POS_SECOND) begin
            n_hex_prefix = r_first_zero && is_x;
        end
        n_pos = (r_pos == POS_LATER) ? r_pos : r_pos + t_pos'(1);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_char <= i_req.char_code;
            r_last <= i_req.is_last;
        end
    end

    // literal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_last)) begin
            r_pos        <= POS_FIRST;
            r_first_zero <= 1'b0;
            r_hex_prefix <= 1'b0;
            r_flags      <= FL_RESET;
            r_hex_acc    <= '0;
            r_dec_acc    <= '0;
            r_oct_acc    <= '0;
            r_bin_acc    <= '0;
        end else if (proc) begin
            r_pos        <= n_pos;
            r_first_zero <= n_first_zero;
            r_hex_prefix <= n_hex_prefix;
            r_flags      <= n_flags;
            r_hex_acc    <= n_hex_acc;
            r_dec_acc    <= n_dec_acc;
            r_oct_acc    <= n_oct_acc;
            r_bin_acc    <= n_bin_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && r_last) begin
            r_hex_ok  <= n_hex_ok;
            r_dec_ok  <= n_dec_ok;
            r_oct_ok  <= n_oct_ok;
            r_bin_ok  <= n_bin_ok;
            r_hex_val <= n_hex_acc;
            r_dec_val <= n_dec_acc;
            r_oct_val <= n_oct_acc;
            r_bin_val <= n_bin_acc;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.hex_ok    = r_hex_ok;
    assign o_res.dec_ok    = r_dec_ok;
    assign o_res.oct_ok    = r_oct_ok;
    assign o_res.bin_ok    = r_bin_ok;
    assign o_res.hex_value = r_hex_val;
    assign o_res.dec_value = r_dec_val;
    assign o_res.oct_value = r_oct_val;
    assign o_res.bin_value = r_bin_val;

endmodule

// ===== design/ncc_checker.sv =====
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks on the literal classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ncc_checker
    import ncc_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_in_last,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_value i_out_hex_value
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_hex_value))
        else $error("stalled result changed");

    // input only blocks behind a stalled result
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    // a fresh result traces back to an earlier taken last character
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result without last character");

endmodule

bind number_literal_classify_convert_core ncc_checker u_ncc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_in_last       (i_req.is_last),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_hex_value (o_res.hex_value)
);
